[rtl/mvma_pkg.sv]
// Package for the matrix-vector multiply-accumulate block.
// Holds field widths, the input opcodes, configuration register indexes and the result type.
// Used by the channel interfaces, the top level and the port checker.
package mvma_pkg;

  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 11;
  localparam int ACC_W  = 64;
  localparam int PROD_W = 64;
  localparam int TERM_W = 48;

  typedef enum logic [1:0] {
    OP_X_WRITE   = 2'd0,
    OP_ROW_START = 2'd1,
    OP_ELEMENT   = 2'd2
  } opcode_t;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic signed [VAL_W-1:0] y_value;
    logic                    last_row;
  } result_t;

endpackage

[rtl/mvma_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
// Depends on mvma_pkg for the field widths.
interface mvma_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic [mvma_pkg::IDX_W-1:0]        index;
  logic signed [mvma_pkg::VAL_W-1:0] value;

  modport source(output valid, output opcode, output index, output value, input ready);
  modport sink(input valid, input opcode, input index, input value, output ready);
endinterface

interface mvma_out_if;
  logic                              valid;
  logic                              ready;
  logic [mvma_pkg::IDX_W-1:0]        row;
  logic signed [mvma_pkg::VAL_W-1:0] y_value;
  logic                              last_row;

  modport source(output valid, output row, output y_value, output last_row, input ready);
  modport sink(input valid, input row, input y_value, input last_row, output ready);
endinterface

[rtl/mvma_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; contents are not reset.
module mvma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/matrix_vector_multiply_accumulate.sv]
// Top level: y <- y + A*x in Q16.16, one input transaction per cycle, x held in a RAM.
// An element's result passes through the registered RAM read, multiply, rounding and
// accumulate steps into an 8-entry result queue; ready drops only when 8 results are queued
// or owed, so with the output drained one item is taken every cycle. Synchronous active-low
// reset clears the pipeline, queue, accumulator, row and registers (both counts to 1024); the
// x store is not cleared and needs no clearing pass.
module matrix_vector_multiply_accumulate #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mvma_in_if.sink                    in_ch,
  mvma_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [mvma_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int XDEPTH     = (MAX_COLS < 1024) ? MAX_COLS : 1024;
  localparam int XAW        = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
  localparam int RLIM       = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
  localparam int FIFO_DEPTH = 8;
  localparam int FAW        = $clog2(FIFO_DEPTH);
  localparam int FCW        = FAW + 1;
  localparam int CW         = mvma_pkg::CNT_W;
  localparam int IW         = mvma_pkg::IDX_W;
  localparam int VW         = mvma_pkg::VAL_W;
  localparam int AW         = mvma_pkg::ACC_W;
  localparam int PW         = mvma_pkg::PROD_W;
  localparam int TW         = mvma_pkg::TERM_W;
  localparam logic [CW-1:0] COL_LIM = CW'(XDEPTH);
  localparam logic [CW-1:0] ROW_LIM = CW'(RLIM);
  localparam logic [CW-1:0] CNT_RESET = CW'(1024);

  logic [CW-1:0] cols_r, rows_r;
  logic [CW-1:0] ncols, nrows;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CNT_RESET;
      rows_r <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (mvma_pkg::cfg_idx_t'(cfg_index))
        mvma_pkg::CFG_COLS: cols_r <= cfg_wdata;
        mvma_pkg::CFG_ROWS: rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ncols = (cols_r == '0) ? CW'(1) : ((cols_r > COL_LIM) ? COL_LIM : cols_r);
  assign nrows = (rows_r == '0) ? CW'(1) : ((rows_r > ROW_LIM) ? ROW_LIM : rows_r);

  // Decode of the incoming transaction.
  logic          acc_in;
  logic [CW-1:0] idx_ext;
  logic          x_we, elem_ok, row_go, emit0;

  assign acc_in  = in_ch.valid && in_ch.ready;
  assign idx_ext = {1'b0, in_ch.index};

  always_comb begin
    x_we    = 1'b0;
    elem_ok = 1'b0;
    row_go  = 1'b0;
    unique case (mvma_pkg::opcode_t'(in_ch.opcode))
      mvma_pkg::OP_X_WRITE:   x_we    = acc_in && (idx_ext < COL_LIM);
      mvma_pkg::OP_ROW_START: row_go  = acc_in;
      mvma_pkg::OP_ELEMENT:   elem_ok = acc_in && (idx_ext < ncols);
      default: ;
    endcase
  end

  assign emit0 = elem_ok && (idx_ext == ncols - CW'(1));

  logic [VW-1:0] x_rdata;

  mvma_ram #(
    .WIDTH(VW),
    .DEPTH(XDEPTH)
  ) u_x_ram (
    .clk  (clk),
    .we   (x_we),
    .waddr(in_ch.index[XAW-1:0]),
    .wdata(in_ch.value),
    .re   (elem_ok),
    .raddr(in_ch.index[XAW-1:0]),
    .rdata(x_rdata)
  );

  // Stage 1: x entry arrives from the RAM; multiply.
  logic                 s1_v_r, s1_row_start_r, s1_emit_r;
  logic signed [VW-1:0] s1_val_r;
  logic [IW-1:0]        s1_idx_r;
  logic signed [PW-1:0] prod_nxt;

  // Stage 2: product or initial y; round to Q16.16.
  logic                 s2_v_r, s2_row_start_r, s2_emit_r;
  logic signed [PW-1:0] s2_prod_r;
  logic [IW-1:0]        s2_idx_r;
  logic signed [PW-1:0] rnd;
  logic signed [TW-1:0] term_nxt;

  // Stage 3: accumulate and emit.
  logic                 s3_v_r, s3_row_start_r, s3_emit_r;
  logic signed [TW-1:0] s3_term_r;
  logic [IW-1:0]        s3_idx_r;

  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [IW-1:0]        cur_row_r;

  assign prod_nxt = s1_row_start_r ? PW'(s1_val_r) : s1_val_r * $signed(x_rdata);
  assign rnd      = s2_prod_r + PW'(32768);
  assign term_nxt = s2_row_start_r ? s2_prod_r[TW-1:0] : rnd[PW-1:16];

  always_comb begin
    if (s3_row_start_r) begin
      acc_nxt = AW'(s3_term_r);
    end else begin
      acc_nxt = acc_r + AW'(s3_term_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_emit_r <= 1'b0;
      s3_v_r    <= 1'b0;
      s3_emit_r <= 1'b0;
      acc_r     <= '0;
      cur_row_r <= '0;
    end else begin
      s1_v_r    <= elem_ok || row_go;
      s1_emit_r <= emit0;
      s2_v_r    <= s1_v_r;
      s2_emit_r <= s1_v_r && s1_emit_r;
      s3_v_r    <= s2_v_r;
      s3_emit_r <= s2_v_r && s2_emit_r;
      if (s3_v_r) begin
        acc_r <= acc_nxt;
        if (s3_row_start_r) begin
          cur_row_r <= s3_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_row_start_r <= row_go;
    s1_val_r       <= in_ch.value;
    s1_idx_r       <= in_ch.index;
    s2_row_start_r <= s1_row_start_r;
    s2_prod_r      <= prod_nxt;
    s2_idx_r       <= s1_idx_r;
    s3_row_start_r <= s2_row_start_r;
    s3_term_r      <= term_nxt;
    s3_idx_r       <= s2_idx_r;
  end

  // Result formation and queue.
  logic                 push, pop;
  logic                 sat_ok;
  mvma_pkg::result_t    res_nxt;
  mvma_pkg::result_t    fifo_mem_r [FIFO_DEPTH];
  logic [FAW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0]       cnt_r, credit;

  assign push   = s3_v_r && s3_emit_r;
  assign pop    = out_ch.valid && out_ch.ready;
  assign sat_ok = (&acc_nxt[AW-1:VW-1]) || !(|acc_nxt[AW-1:VW-1]);

  always_comb begin
    res_nxt.row      = cur_row_r;
    res_nxt.last_row = ({1'b0, cur_row_r} == nrows - CW'(1));
    if (sat_ok) begin
      res_nxt.y_value = acc_nxt[VW-1:0];
    end else if (acc_nxt[AW-1]) begin
      res_nxt.y_value = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res_nxt.y_value = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FAW'(1);
      end
      cnt_r <= cnt_r + FCW'(push) - FCW'(pop);
    end
  end

  // Results still owed by the pipeline reserve their queue slots.
  assign credit = cnt_r + FCW'(s1_v_r && s1_emit_r) + FCW'(s2_v_r && s2_emit_r)
                + FCW'(s3_v_r && s3_emit_r);

  assign in_ch.ready     = (credit < FCW'(FIFO_DEPTH));
  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.row      = fifo_mem_r[rd_ptr_r].row;
  assign out_ch.y_value  = fifo_mem_r[rd_ptr_r].y_value;
  assign out_ch.last_row = fifo_mem_r[rd_ptr_r].last_row;

endmodule

[rtl/mvma_chk.sv]
// Port checker for the matrix-vector multiply-accumulate top level, bound to it below.
// Depends on mvma_pkg for the opcode and field widths.
module mvma_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        in_opcode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mvma_pkg::IDX_W-1:0]        out_row,
  input logic signed [mvma_pkg::VAL_W-1:0] out_y_value,
  input logic                              out_last_row
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_y_value)
      && $stable(out_last_row))
    else $error("Stalled result transaction changed.");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while no result is queued.");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready
      && (in_opcode == mvma_pkg::OP_ELEMENT), 4))
    else $error("Result appeared without an element transaction four cycles earlier.");

endmodule

bind matrix_vector_multiply_accumulate mvma_chk u_mvma_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_opcode   (in_ch.opcode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_row     (out_ch.row),
  .out_y_value (out_ch.y_value),
  .out_last_row(out_ch.last_row)
);
